// ===== rtl/core/pst_pkg.sv =====
// ----------------------------------------------------------------------------
// pst_pkg
// Types and constants shared by the pid to socket table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pst_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // request kinds
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_LOOKUP = 2'd1;
  localparam logic [1:0] REQ_UPDATE = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_INVALID   = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [31:0]        proc_id;
    logic signed [31:0] sock_in;
  } pst_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               found;
    logic signed [31:0] sock_out;
  } pst_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/pid_socket_table.sv =====
// Sequence: clear or a zero pid goes from acceptance straight to the result state;
//   otherwise the single compare unit walks the slots one by one from slot 0
//   (stops at the matching slot, walks the whole table on a miss).
// Throughput: one request at a time; the next is taken once the sequencer idles.
// Reset: synchronous active-low; all slots invalid, no result pending.
// Slot pid/socket storage is not cleared and is read only behind a valid bit.
// ----------------------------------------------------------------------------
// pid_socket_table
// Bounded pid to socket table searched slot by slot with one comparator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pid_socket_table
  import pst_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire pst_req_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output pst_rsp_t      out_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  logic [1:0]         state_r, state_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [IDX_W-1:0]   tgt_r, tgt_nxt;
  logic               hit_r, hit_nxt;
  logic               free_r, free_nxt;
  logic               out_valid_r, out_valid_nxt;
  pst_req_t           req_r;
  pst_rsp_t           out_r, out_nxt;
  logic signed [31:0] hit_sock_r, hit_sock_nxt;

  logic [ENTRIES-1:0] valid_r;
  logic [31:0]        slot_pid [ENTRIES];
  logic signed [31:0] slot_sock [ENTRIES];
  logic [31:0]        rd_pid_r;
  logic signed [31:0] rd_sock_r;

  logic accept;
  logic deliver;
  logic slot_match;
  logic wr_ins;
  logic wr_upd;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign deliver   = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  // the one compare unit: slot at idx_r against the request pid
  assign slot_match = valid_r[idx_r] && (rd_pid_r == req_r.proc_id);

  assign wr_ins = deliver && (req_r.req_type == REQ_INSERT) && (req_r.proc_id != 32'd0)
                  && !hit_r && free_r;
  assign wr_upd = deliver && (req_r.req_type == REQ_UPDATE) && (req_r.proc_id != 32'd0)
                  && hit_r;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    tgt_nxt       = tgt_r;
    hit_nxt       = hit_r;
    free_nxt      = free_r;
    hit_sock_nxt  = hit_sock_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;

    case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        if (accept) begin
          hit_nxt  = 1'b0;
          free_nxt = 1'b0;
          if ((in_data.req_type == REQ_CLEAR) || (in_data.proc_id == 32'd0)) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        idx_nxt = idx_r + IDX_W'(1);
        if (slot_match) begin
          hit_nxt      = 1'b1;
          tgt_nxt      = idx_r;
          hit_sock_nxt = rd_sock_r;
          state_nxt    = S_FIN;
        end else begin
          if (!valid_r[idx_r] && !free_r) begin
            free_nxt = 1'b1;
            tgt_nxt  = idx_r;
          end
          if (idx_r == LAST_IDX) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        idx_nxt = '0;
        if (deliver) begin
          out_valid_nxt    = 1'b1;
          out_nxt.sock_out = '1;
          out_nxt.found    = 1'b0;
          out_nxt.status   = ST_OK;
          if (req_r.req_type == REQ_CLEAR) begin
            out_nxt.status = ST_OK;
          end else if (req_r.proc_id == 32'd0) begin
            out_nxt.status = ST_INVALID;
          end else begin
            out_nxt.found = hit_r;
            if (req_r.req_type == REQ_INSERT) begin
              if (!hit_r && !free_r) begin
                out_nxt.status = ST_FULL;
              end
            end else if (!hit_r) begin
              out_nxt.status = ST_NOT_FOUND;
            end else if (req_r.req_type == REQ_LOOKUP) begin
              out_nxt.sock_out = hit_sock_r;
            end
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      idx_r       <= '0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      hit_r       <= hit_nxt;
      free_r      <= free_nxt;
      if (deliver && (req_r.req_type == REQ_CLEAR)) begin
        valid_r <= '0;
      end else if (wr_ins) begin
        valid_r[tgt_r] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    tgt_r      <= tgt_nxt;
    hit_sock_r <= hit_sock_nxt;
    out_r      <= out_nxt;
    if (accept) begin
      req_r <= in_data;
    end
  end

  // slot storage: one write port, read registered at the next scan index
  always_ff @(posedge clk) begin
    if (wr_ins) begin
      slot_pid[tgt_r] <= req_r.proc_id;
    end
    if (wr_ins || wr_upd) begin
      slot_sock[tgt_r] <= req_r.sock_in;
    end
    rd_pid_r  <= slot_pid[idx_nxt];
    rd_sock_r <= slot_sock[idx_nxt];
  end

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pid to socket table. Requests go in as beats on
// the input channel under random gaps; a shadow table predicts every response
// and each response beat is checked field by field against the oldest
// prediction. Covers the zero pid, duplicate insert, full table, misses,
// clear, a long output hold-off and a long random run over small pid pools.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import pst_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 40;
  localparam int MAX_PRINTS  = 50;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  pst_req_t in_data   = '0;
  logic     out_stall = 1'b0;
  logic     in_stall;
  logic     out_valid;
  pst_rsp_t out_data;

  // shadow table
  logic        mdl_valid [ENTRIES];
  logic [31:0] mdl_pid   [ENTRIES];
  logic [31:0] mdl_sock  [ENTRIES];

  pst_rsp_t    pending_rsp[$];
  int          err_count = 0;
  int          rsp_count = 0;
  bit          idle_on   = 1'b1;
  int          hold_len  = 0;
  int          rx_gap    = 0;
  int          quiet     = 0;
  logic [31:0] pid_pool [32];
  int          pool_size = 10;

  pid_socket_table DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic pst_rsp_t table_predict(input pst_req_t r);
    pst_rsp_t rsp;
    int       hit;
    int       free_idx;
    int       i;
    rsp.status   = ST_OK;
    rsp.found    = 1'b0;
    rsp.sock_out = '1;
    hit          = -1;
    free_idx     = -1;
    if (r.req_type == REQ_CLEAR) begin
      for (i = 0; i < ENTRIES; i++) mdl_valid[i] = 1'b0;
    end else if (r.proc_id == '0) begin
      rsp.status = ST_INVALID;
    end else begin
      // walk downwards so the lowest index wins
      for (i = ENTRIES - 1; i >= 0; i--) begin
        if (mdl_valid[i] && mdl_pid[i] == r.proc_id) hit = i;
        if (!mdl_valid[i]) free_idx = i;
      end
      rsp.found = (hit >= 0);
      case (r.req_type)
        REQ_INSERT: begin
          if (hit < 0) begin
            if (free_idx < 0) begin
              rsp.status = ST_FULL;
            end else begin
              mdl_valid[free_idx] = 1'b1;
              mdl_pid[free_idx]   = r.proc_id;
              mdl_sock[free_idx]  = r.sock_in;
            end
          end
        end
        REQ_LOOKUP: begin
          if (hit < 0) rsp.status = ST_NOT_FOUND;
          else rsp.sock_out = mdl_sock[hit];
        end
        REQ_UPDATE: begin
          if (hit < 0) rsp.status = ST_NOT_FOUND;
          else mdl_sock[hit] = r.sock_in;
        end
        default: ;
      endcase
    end
    return rsp;
  endfunction

  function automatic pst_req_t mk_req(input logic [1:0] kind, input logic [31:0] pid,
                                      input logic [31:0] sock);
    pst_req_t r;
    r.req_type = kind;
    r.proc_id  = pid;
    r.sock_in  = sock;
    return r;
  endfunction

  task automatic report_err(input string msg);
    if (err_count < MAX_PRINTS) $display("ERROR: %s", msg);
    err_count++;
  endtask

  // one beat on the input channel; the prediction is taken at acceptance
  task automatic send_req(input pst_req_t r);
    int gap;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_rsp.push_back(table_predict(r));
  endtask

  task automatic check_rsp(input pst_rsp_t got);
    pst_rsp_t want;
    if (pending_rsp.size() == 0) begin
      report_err($sformatf("response %0d arrived with nothing pending", rsp_count));
    end else begin
      want = pending_rsp.pop_front();
      if (got.status !== want.status)
        report_err($sformatf("response %0d status %0d, expected %0d",
                             rsp_count, got.status, want.status));
      if (got.found !== want.found)
        report_err($sformatf("response %0d found %0b, expected %0b",
                             rsp_count, got.found, want.found));
      if (got.sock_out !== want.sock_out)
        report_err($sformatf("response %0d sock_out %h, expected %h",
                             rsp_count, got.sock_out, want.sock_out));
    end
    rsp_count++;
  endtask

  // receiver: per-beat random hold, plus the long hold-off when requested
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      check_rsp(out_data);
      rx_gap = idle_on ? $urandom_range(0, 9) : 0;
    end
    if (hold_len > 0) begin
      out_stall <= 1'b1;
      hold_len--;
    end else if (rx_gap > 0) begin
      out_stall <= 1'b1;
      rx_gap--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("timeout: no beat accepted for %0d cycles", QUIET_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic test_zero_pid;
    send_req(mk_req(REQ_INSERT, 32'h0, 32'h1234_5678));
    send_req(mk_req(REQ_LOOKUP, 32'h0, 32'h0));
    send_req(mk_req(REQ_UPDATE, 32'h0, 32'hFFFF_FFFF));
  endtask

  task automatic test_basic_ops;
    send_req(mk_req(REQ_INSERT, 32'h0000_0001, 32'h7FFF_FFFF));
    send_req(mk_req(REQ_INSERT, 32'hFFFF_FFFF, 32'h8000_0000));
    send_req(mk_req(REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0));
    send_req(mk_req(REQ_UPDATE, 32'h0000_0001, 32'h0000_0000));
    send_req(mk_req(REQ_LOOKUP, 32'h0000_0001, 32'hFFFF_FFFF));
    // duplicate insert keeps the stored socket
    send_req(mk_req(REQ_INSERT, 32'h0000_0001, 32'h5555_AAAA));
    send_req(mk_req(REQ_LOOKUP, 32'h8000_0000, 32'h0));
    send_req(mk_req(REQ_UPDATE, 32'h7FFF_FFFE, 32'h1));
  endtask

  task automatic test_fill;
    int i;
    for (i = 0; i < ENTRIES - 2; i++)
      send_req(mk_req(REQ_INSERT, 32'hA5A5_0000 | i, $urandom));
    send_req(mk_req(REQ_INSERT, 32'h5A5A_5A5A, 32'hDEAD_BEEF));
    // clear with a zero pid is still a clear
    send_req(mk_req(REQ_CLEAR, 32'h0, 32'h0));
    send_req(mk_req(REQ_LOOKUP, 32'h0000_0001, 32'h0));
  endtask

  task automatic test_backpressure;
    int i;
    idle_on  = 1'b0;
    hold_len = 80;
    send_req(mk_req(REQ_INSERT, 32'h0000_0042, 32'h0000_0007));
    for (i = 0; i < 7; i++)
      send_req(mk_req((i % 2) ? REQ_LOOKUP : REQ_UPDATE, 32'h0000_0042, $urandom));
  endtask

  function automatic pst_req_t rand_req();
    pst_req_t r;
    int       roll;
    roll      = $urandom_range(0, 99);
    r.sock_in = $urandom;
    r.proc_id = ($urandom_range(0, 9) == 0) ? $urandom
                                             : pid_pool[$urandom_range(0, pool_size - 1)];
    if (roll < 2) begin
      r.req_type = REQ_CLEAR;
      if ($urandom_range(0, 1)) r.proc_id = '0;
    end else if (roll < 7) begin
      r.req_type = 2'($urandom_range(0, 2));
      r.proc_id  = '0;
    end else if (roll < 47) begin
      r.req_type = REQ_INSERT;
    end else if (roll < 77) begin
      r.req_type = REQ_LOOKUP;
    end else begin
      r.req_type = REQ_UPDATE;
    end
    return r;
  endfunction

  task automatic test_random;
    int blk;
    int i;
    for (blk = 0; blk < 12; blk++) begin
      idle_on   = ($urandom_range(0, 3) != 0);
      pool_size = (blk % 2) ? 32 : 10;
      for (i = 0; i < 32; i++) begin
        pid_pool[i] = $urandom;
        if (pid_pool[i] == '0) pid_pool[i] = 32'h0000_0100;
      end
      for (i = 0; i < 152; i++) send_req(rand_req());
    end
  endtask

  initial begin
    int i;
    for (i = 0; i < ENTRIES; i++) begin
      mdl_valid[i] = 1'b0;
      mdl_pid[i]   = '0;
      mdl_sock[i]  = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_zero_pid();
    test_basic_ops();
    test_fill();
    test_backpressure();
    test_random();
    in_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
